[hw/rtl/apsa_pkg.sv]
// shared types and constants for the accelerometer poll sequencer and averager
// used by apsa_ctrl, apsa_dp and accel_poll_sequence_and_average
// no dependencies
package apsa_pkg;

	// samples per average (1 to 64)
	localparam int AVERAGE_COUNT = 22;
	localparam int CNT_W         = 6;
	localparam logic [CNT_W-1:0] AVG_LAST = CNT_W'(AVERAGE_COUNT - 1);

	localparam int SUM_W  = 24;
	localparam int WORD_W = 16;
	localparam int PROD_W = 49;

	// exact floor(x / AVERAGE_COUNT) for x below 2^SUM_W:
	// (x * RECIP) >> DIV_SHIFT, RECIP = ceil(2^DIV_SHIFT / AVERAGE_COUNT)
	localparam int DIV_SHIFT = SUM_W + $clog2(AVERAGE_COUNT);
	localparam longint RECIP_L = ((64'd1 << DIV_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
	localparam logic [24:0] RECIP = 25'(RECIP_L);

	// gain is unsigned Q5.11
	localparam int GAIN_FRAC = 11;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_BUS_RESET = 3'd1,
		ACT_READ      = 3'd2,
		ACT_WR_IDLE   = 3'd3,
		ACT_WR_RUN    = 3'd4
	} action_t;

	// sequencer steps with a special meaning
	localparam logic [2:0] STEP_START    = 3'd0;
	localparam logic [2:0] STEP_IDLE_CFG = 3'd2;
	localparam logic [2:0] STEP_RUN_CFG  = 3'd4;
	localparam logic [2:0] STEP_RUN      = 3'd5;

	typedef enum logic [2:0] {
		REG_OFF_X  = 3'd0,
		REG_OFF_Y  = 3'd1,
		REG_OFF_Z  = 3'd2,
		REG_GAIN_X = 3'd3,
		REG_GAIN_Y = 3'd4,
		REG_GAIN_Z = 3'd5
	} reg_idx_t;

	localparam logic [15:0] OFF_X_RST  = 16'd84;
	localparam logic [15:0] OFF_Y_RST  = 16'd22;
	localparam logic [15:0] OFF_Z_RST  = 16'hFB41;
	localparam logic [15:0] GAIN_X_RST = 16'd34882;
	localparam logic [15:0] GAIN_Y_RST = 16'd34005;
	localparam logic [15:0] GAIN_Z_RST = 16'd37809;

	// axis order in arrays: 0 x, 1 y, 2 z
	typedef struct packed {
		logic [2:0][15:0] off;
		logic [2:0][15:0] gain;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       exec;
		logic       div;
		logic       scale;
		logic       clear_sums;
		logic       load_out;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic avg_due;
	} sts_t;

endpackage

[hw/rtl/apsa_ctrl.sv]
// controller for the poll sequencer and averager: item handshake, axis loop, output slot
// depends on apsa_pkg
module apsa_ctrl
	import apsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_SCALE,
		ST_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] axis_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.axis       = axis_q;
		cmd.capture    = (state_q == ST_IDLE) && s_tvalid;
		cmd.exec       = (state_q == ST_EXEC);
		cmd.div        = (state_q == ST_DIV);
		cmd.scale      = (state_q == ST_SCALE);
		cmd.clear_sums = (state_q == ST_SCALE) && (axis_q == 2'd2);
		cmd.load_out   = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					axis_q <= 2'd0;
					if (sts.avg_due)
						state_q <= ST_DIV;
					else
						state_q <= ST_DONE;
				end
				ST_DIV: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (axis_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_DIV;
					end
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/apsa_dp.sv]
// datapath: sequencer step, running sums, shared multiplier for divide and scale, result register
// depends on apsa_pkg
module apsa_dp
	import apsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  cfg_t        cfg,
	input  logic        in_kind,
	input  logic [55:0] in_data,
	output logic        out_ready,
	output logic [55:0] out_data
);

	logic                   kind_q;
	logic                   ok_q;
	logic [2:0][WORD_W-1:0] word_q;
	logic [2:0]             step_q;
	logic [CNT_W-1:0]       samples_q;
	logic [2:0][SUM_W-1:0]  sum_q;
	action_t                act_q;
	logic                   rdy_q;
	logic [SUM_W-1:0]       quo_q;
	logic [2:0][15:0]       res_q;
	action_t                out_act_q;
	logic                   out_rdy_q;
	logic [2:0][15:0]       out_val_q;

	logic [2:0]             step_nxt;
	action_t                act_nxt;
	logic                   sampling;
	logic [2:0][SUM_W-1:0]  sum_nxt;
	logic [SUM_W-1:0]       sum_sel;
	logic                   sum_neg;
	logic [SUM_W-1:0]       sum_mag;
	logic [SUM_W-1:0]       mul_a;
	logic [24:0]            mul_b;
	logic [PROD_W-1:0]      prod;
	logic [28:0]            scaled_mag;
	logic [15:0]            res_nxt;

	assign sampling    = kind_q && ok_q && (step_q == STEP_RUN);
	assign sts.avg_due = sampling && (samples_q == AVG_LAST);

	always_comb begin
		step_nxt = (step_q == STEP_RUN) ? STEP_RUN : step_q + 3'd1;
		case (step_nxt)
			STEP_IDLE_CFG: act_nxt = ACT_WR_IDLE;
			STEP_RUN_CFG:  act_nxt = ACT_WR_RUN;
			default:       act_nxt = ACT_READ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_nxt[i] = sum_q[i] + {{(SUM_W-WORD_W){word_q[i][WORD_W-1]}}, word_q[i]}
				+ {{(SUM_W-16){cfg.off[i][15]}}, cfg.off[i]};
		end
	end

	// one multiplier: |sum| * reciprocal, then quotient * gain
	always_comb begin
		sum_sel    = sum_q[cmd.axis];
		sum_neg    = sum_sel[SUM_W-1];
		sum_mag    = sum_neg ? (~sum_sel + SUM_W'(1)) : sum_sel;
		mul_a      = cmd.scale ? quo_q : sum_mag;
		mul_b      = cmd.scale ? {9'd0, cfg.gain[cmd.axis]} : RECIP;
		prod       = PROD_W'(mul_a) * PROD_W'(mul_b);
		scaled_mag = prod[GAIN_FRAC +: 29];
		if (!sum_neg)
			res_nxt = (scaled_mag > 29'd32767) ? 16'h7FFF : scaled_mag[15:0];
		else
			res_nxt = (scaled_mag > 29'd32768) ? 16'h8000 : (~scaled_mag[15:0] + 16'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_START;
			samples_q <= '0;
			sum_q     <= '0;
		end else begin
			if (cmd.exec) begin
				if (!kind_q) begin
					step_q <= ok_q ? step_nxt : STEP_START;
				end else if (sampling) begin
					sum_q     <= sum_nxt;
					samples_q <= sts.avg_due ? '0 : samples_q + CNT_W'(1);
				end
			end
			if (cmd.clear_sums)
				sum_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q    <= in_kind;
			ok_q      <= in_data[0];
			// x takes the second word, y the first
			word_q[0] <= in_data[32:17];
			word_q[1] <= in_data[16:1];
			word_q[2] <= in_data[48:33];
		end
		if (cmd.exec) begin
			rdy_q <= sts.avg_due;
			if (!kind_q)
				act_q <= ok_q ? act_nxt : ACT_BUS_RESET;
			else
				act_q <= ACT_NONE;
		end
		if (cmd.div)
			quo_q <= SUM_W'(prod >> DIV_SHIFT);
		if (cmd.scale)
			res_q[cmd.axis] <= res_nxt;
		if (cmd.load_out) begin
			out_act_q <= act_q;
			out_rdy_q <= rdy_q;
			out_val_q <= rdy_q ? res_q : '0;
		end
	end

	assign out_ready = out_rdy_q;
	assign out_data  = {5'd0, out_val_q[2], out_val_q[1], out_val_q[0], out_act_q};

`ifndef SYNTHESIS
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_RUN)
		else $error("sequencer step beyond running step");

	a_samples_bound: assert property (@(posedge clk) disable iff (!arst_n)
		samples_q <= AVG_LAST)
		else $error("sample count beyond average length");

	a_avg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && sts.avg_due) |=> (samples_q == '0))
		else $error("sample count not restarted after average");

	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_sums |=> (sum_q == '0))
		else $error("sums not cleared after average");
`endif

endmodule

[hw/rtl/accel_poll_sequence_and_average.sv]
// Accelerometer bring-up sequencer and sample averager, top level.
// Each item passes the states EXEC and DONE; a read that completes an average also
// passes DIV then SCALE for each axis (two passes of the shared multiplier per axis),
// and DONE loads the output register once it is free. One item at a time, and the next
// item is taken while the previous result waits in the output register.
// arst_n clears the sequencer, sample count and sums and loads register defaults.
module accel_poll_sequence_and_average
	import apsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // bus_ok, byte0, byte1, byte2, byte3, byte4, byte5, zero pad
	input  logic        s_tuser,  // kind
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // action, x_value, y_value, z_value, zero pad
	output logic        m_tuser,  // averages_ready
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg_q;
	cmd_t     cmd;
	sts_t     sts;
	reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off[0]  <= OFF_X_RST;
			cfg_q.off[1]  <= OFF_Y_RST;
			cfg_q.off[2]  <= OFF_Z_RST;
			cfg_q.gain[0] <= GAIN_X_RST;
			cfg_q.gain[1] <= GAIN_Y_RST;
			cfg_q.gain[2] <= GAIN_Z_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_OFF_X:  cfg_q.off[0]  <= pwdata[15:0];
				REG_OFF_Y:  cfg_q.off[1]  <= pwdata[15:0];
				REG_OFF_Z:  cfg_q.off[2]  <= pwdata[15:0];
				REG_GAIN_X: cfg_q.gain[0] <= pwdata[15:0];
				REG_GAIN_Y: cfg_q.gain[1] <= pwdata[15:0];
				REG_GAIN_Z: cfg_q.gain[2] <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OFF_X:  prdata = {16'd0, cfg_q.off[0]};
			REG_OFF_Y:  prdata = {16'd0, cfg_q.off[1]};
			REG_OFF_Z:  prdata = {16'd0, cfg_q.off[2]};
			REG_GAIN_X: prdata = {16'd0, cfg_q.gain[0]};
			REG_GAIN_Y: prdata = {16'd0, cfg_q.gain[1]};
			REG_GAIN_Z: prdata = {16'd0, cfg_q.gain[2]};
			default:    prdata = '0;
		endcase
	end

	apsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	apsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg       (cfg_q),
		.in_kind   (s_tuser),
		.in_data   (s_tdata),
		.out_ready (m_tuser),
		.out_data  (m_tdata)
	);

endmodule

[tb/apsa_poll_checker.sv]
`timescale 1ns / 1ps
// result checker for accel_poll_sequence_and_average: follows the register port and
// both streams, predicts every result and compares it field by field
// depends on apsa_pkg
module apsa_poll_checker
	import apsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		action_t          act;
		logic             rdy;
		logic [2:0][15:0] val;  // x, y, z
	} outcome_t;

	outcome_t awaited_outcomes[$];

	// sequencer and averager state, axis order x, y, z
	logic [2:0]         step;
	logic [5:0]         taken;
	logic signed [23:0] acc [3];
	logic signed [15:0] off [3];
	logic [15:0]        gain [3];

	initial errors = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: mismatch in %s, got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	function automatic logic [15:0] scaled_average(input logic signed [23:0] total,
			input int count, input logic [15:0] g);
		longint q;
		longint p;
		q = longint'(total) / count;
		p = (q * longint'(g)) / 2048;
		if (p > 32767)
			p = 32767;
		else if (p < -32768)
			p = -32768;
		return p[15:0];
	endfunction

	function automatic outcome_t poll_outcome(input logic kind, input logic [55:0] d);
		outcome_t           o;
		logic signed [15:0] feed [3];
		int                 t;
		o.act = ACT_NONE;
		o.rdy = 1'b0;
		o.val = '0;
		if (!kind) begin
			if (!d[0]) begin
				step  = STEP_START;
				o.act = ACT_BUS_RESET;
			end else begin
				if (step < STEP_RUN)
					step = step + 3'd1;
				case (step)
					STEP_IDLE_CFG: o.act = ACT_WR_IDLE;
					STEP_RUN_CFG:  o.act = ACT_WR_RUN;
					default:       o.act = ACT_READ;
				endcase
			end
		end else if (d[0] && step == STEP_RUN) begin
			// axes swapped: x takes the second word, y the first
			feed[0] = d[32:17];
			feed[1] = d[16:1];
			feed[2] = d[48:33];
			for (int a = 0; a < 3; a++) begin
				t      = int'(acc[a]) + int'(feed[a]) + int'(off[a]);
				acc[a] = t[23:0];
			end
			if (int'(taken) + 1 >= AVERAGE_COUNT) begin
				o.rdy = 1'b1;
				for (int a = 0; a < 3; a++) begin
					o.val[a] = scaled_average(acc[a], AVERAGE_COUNT, gain[a]);
					acc[a]   = '0;
				end
				taken = '0;
			end else begin
				taken = taken + 6'd1;
			end
		end
		return o;
	endfunction

	task automatic store_setting();
		case (reg_idx_t'(paddr[4:2]))
			REG_OFF_X:  off[0]  = pwdata[15:0];
			REG_OFF_Y:  off[1]  = pwdata[15:0];
			REG_OFF_Z:  off[2]  = pwdata[15:0];
			REG_GAIN_X: gain[0] = pwdata[15:0];
			REG_GAIN_Y: gain[1] = pwdata[15:0];
			REG_GAIN_Z: gain[2] = pwdata[15:0];
			default: ;
		endcase
	endtask

	task automatic compare_result();
		outcome_t want;
		if (awaited_outcomes.size() == 0) begin
			report_mismatch("transfer with nothing outstanding", m_tdata, '0);
			return;
		end
		want = awaited_outcomes.pop_front();
		if (m_tdata[2:0] != want.act)
			report_mismatch("action", m_tdata[2:0], want.act);
		if (m_tuser != want.rdy)
			report_mismatch("averages_ready", m_tuser, want.rdy);
		if (m_tdata[18:3] != want.val[0])
			report_mismatch("x_value", m_tdata[18:3], want.val[0]);
		if (m_tdata[34:19] != want.val[1])
			report_mismatch("y_value", m_tdata[34:19], want.val[1]);
		if (m_tdata[50:35] != want.val[2])
			report_mismatch("z_value", m_tdata[50:35], want.val[2]);
		if (m_tdata[55:51] != '0)
			report_mismatch("tdata padding", m_tdata[55:51], '0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step    = STEP_START;
			taken   = '0;
			acc     = '{default: '0};
			off     = '{OFF_X_RST, OFF_Y_RST, OFF_Z_RST};
			gain    = '{GAIN_X_RST, GAIN_Y_RST, GAIN_Z_RST};
			awaited_outcomes.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready)
				compare_result();
			if (psel && penable && pwrite && pready)
				store_setting();
			if (s_tvalid && s_tready)
				awaited_outcomes.push_back(poll_outcome(s_tuser, s_tdata));
			pending <= awaited_outcomes.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// top of the accel_poll_sequence_and_average testbench: clock, reset, register
// writes, input transfers and receiver stalls; checking is done in apsa_poll_checker
// depends on apsa_pkg, apsa_poll_checker and the block under test
module tb
	import apsa_pkg::*;
();

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tuser;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	logic calm       = 1'b0;  // no idling on either side
	int   stall_req  = 0;
	int   stall_ack  = 0;
	int   stall_left = 0;
	int   errors;
	int   pending;

	accel_poll_sequence_and_average dut (.*);

	apsa_poll_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.errors, .pending
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// receiver: random back-pressure, plus one long hold-off on request
	always @(posedge clk) begin
		if (stall_req != stall_ack) begin
			stall_ack  <= stall_req;
			stall_left <= 300;
			m_tready   <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 10);
		end
	end

	task automatic write_setting(input reg_idx_t idx, input logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx) << 2;
		pwdata  <= {16'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic offer(input logic kind, input logic [55:0] data);
		if (!calm && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// sensor bytes of a tick are ignored but still toggled
	task automatic send_tick(input logic ok);
		offer(1'b0, {7'b0, 16'($urandom), 32'($urandom), ok});
	endtask

	task automatic send_sample(input logic ok, input logic [15:0] w0, input logic [15:0] w1,
			input logic [15:0] w2);
		offer(1'b1, {7'b0, w2, w1, w0, ok});
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(7))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'hFFFF;
			3:       return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// stop offering and wait until every transfer has produced its result
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		logic [15:0] offs [3];
		logic [15:0] gains [3];
		int          r;
		wait (arst_n);
		@(posedge clk);

		// bring-up sequence and its corner cases on the reset settings
		send_sample(1'b1, 16'h7FFF, 16'h8000, 16'hFFFF);
		send_tick(1'b0);
		repeat (6) send_tick(1'b1);
		send_sample(1'b0, 16'h0000, 16'h0000, 16'h0000);
		send_sample(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_sample(1'b1, 16'h8000, 16'h8000, 16'h8000);
		send_sample(1'b1, 16'h0000, 16'hFFFF, 16'h0000);
		send_sample(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_sample(1'b1, pick_word(), pick_word(), pick_word());
		send_tick(1'b0);
		send_sample(1'b1, 16'h1234, 16'h5678, 16'h9ABC);
		repeat (5) send_tick(1'b1);
		send_tick(1'b1);

		for (int phase = 0; phase < 8; phase++) begin
			settle();
			calm <= (phase == 3);
			case (phase)
				0: begin
					offs  = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
					gains = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
				end
				1: begin
					offs  = '{16'h8000, 16'h8000, 16'h8000};
					gains = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
				end
				2: begin
					offs  = '{16'h0000, 16'h0000, 16'h0000};
					gains = '{16'h0000, 16'h0000, 16'h0000};
				end
				3: begin
					offs  = '{16'($urandom), 16'($urandom), 16'($urandom)};
					gains = '{16'd2048, 16'd2048, 16'd2048};
				end
				6: begin
					offs  = '{16'hFFFF, 16'h0001, 16'h0000};
					gains = '{16'h0001, 16'h0001, 16'h0001};
				end
				default: begin
					offs  = '{16'($urandom), 16'($urandom), 16'($urandom)};
					gains = '{16'($urandom), 16'($urandom), 16'($urandom)};
				end
			endcase
			write_setting(REG_OFF_X, offs[0]);
			write_setting(REG_OFF_Y, offs[1]);
			write_setting(REG_OFF_Z, offs[2]);
			write_setting(REG_GAIN_X, gains[0]);
			write_setting(REG_GAIN_Y, gains[1]);
			write_setting(REG_GAIN_Z, gains[2]);
			@(posedge clk);
			// long receiver hold-off while items keep coming
			if (phase == 5)
				stall_req <= stall_req + 1;

			send_tick(1'b0);
			repeat (5) send_tick(1'b1);
			repeat (54) begin
				r = $urandom_range(99);
				if (r < 80) begin
					send_sample(1'b1, pick_word(), pick_word(), pick_word());
				end else if (r < 86) begin
					send_sample(1'b0, pick_word(), pick_word(), pick_word());
				end else if (r < 94) begin
					send_tick(1'b1);
				end else begin
					// bus fault: the sample count survives a fresh bring-up
					send_tick(1'b0);
					send_sample(1'b1, pick_word(), pick_word(), pick_word());
					repeat (5) send_tick(1'b1);
				end
			end
		end

		settle();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
